/* src/pofbc_pkg.sv */
// Package: shared constants, codes and control types for the free block cache.
`default_nettype none
package pofbc_pkg;

  // defaults for the top level parameters
  localparam int unsigned NUM_CACHES_DEF = 8;
  localparam int unsigned NUM_ORDERS_DEF = 16;
  localparam int unsigned MAX_LANE_DEF   = 16;

  // log2 of the smallest block in bytes
  localparam int unsigned MIN_BLOCK_LOG2 = 12;
  // most results one drain transaction returns
  localparam int unsigned MAX_RESULTS    = 16;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned CINDEX_W = 3;
  localparam int unsigned ORDER_W  = 4;
  localparam int unsigned OFFSET_W = 48;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned BYTES_W  = 40;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned BUDGET_W = 32;
  localparam int unsigned SHIFT_W  = 7;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 32'd1048576;

  localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DRAIN = 2'd2;

  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNCACHED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DRAINED  = 3'd4;

  // what the current request turns into once its fill count is known
  typedef enum logic [1:0] {
    OC_IGNORE,
    OC_SINGLE,
    OC_POP
  } outcome_e;

  typedef struct packed {
    logic capture;      // take the input transaction, read its fill count
    logic commit;       // apply fill, store and counter updates
    logic load_single;  // load the one-shot result into the output register
    logic start_pop;    // first store read of a pop run
    logic pop_next;     // following store read of a pop run
    logic pop_load;     // load popped offset into the output register
  } pofbc_cmd_t;

  typedef struct packed {
    outcome_e outcome;
    logic     out_free;
    logic     pop_last;
  } pofbc_sts_t;

endpackage
`default_nettype wire

/* src/per_order_free_block_cache.sv */
// Top level of the per-order free block cache.
//
//  channel  handshake              payload
//  -------  ---------------------  ------------------------------------------------
//  in       in_valid_i/in_stall_o  opcode_i cache_index_i order_i block_offset_i
//  out      out_valid_o/out_stall_i status_o result_offset_o result_order_o last_o
//                                  cached_bytes_o hit_total_o miss_total_o
//  cfg      cfg_we_i               cfg_wdata_i (budget in bytes)
//
//  One transaction at a time: an accept phase, then an execute phase that uses the
//  registered fill count read. An allocate hit and a drain then run a pop phase
//  with one offset store read per entry; a drain returns up to MAX_RESULTS entries.
//  Reset clears fill counts at once through per-stack valid bits; no sweep.
//  A stalled output holds a single result's execute phase, or the pop phase, until the register frees.
`default_nettype none
module per_order_free_block_cache import pofbc_pkg::*; #(
  parameter int unsigned NUM_CACHES = NUM_CACHES_DEF,
  parameter int unsigned NUM_ORDERS = NUM_ORDERS_DEF,
  parameter int unsigned MAX_LANE   = MAX_LANE_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [BUDGET_W-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [OPCODE_W-1:0] opcode_i,
  input  wire logic [CINDEX_W-1:0] cache_index_i,
  input  wire logic [ORDER_W-1:0]  order_i,
  input  wire logic [OFFSET_W-1:0] block_offset_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [STATUS_W-1:0] status_o,
  output logic      [OFFSET_W-1:0] result_offset_o,
  output logic      [ORDER_W-1:0]  result_order_o,
  output logic                     last_o,
  output logic      [BYTES_W-1:0]  cached_bytes_o,
  output logic      [COUNT_W-1:0]  hit_total_o,
  output logic      [COUNT_W-1:0]  miss_total_o
);

  pofbc_cmd_t cmd;
  pofbc_sts_t sts;

  pofbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pofbc_dp #(
    .NUM_CACHES (NUM_CACHES),
    .NUM_ORDERS (NUM_ORDERS),
    .MAX_LANE   (MAX_LANE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .opcode_i        (opcode_i),
    .cache_index_i   (cache_index_i),
    .order_i         (order_i),
    .block_offset_i  (block_offset_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .result_offset_o (result_offset_o),
    .result_order_o  (result_order_o),
    .last_o          (last_o),
    .cached_bytes_o  (cached_bytes_o),
    .hit_total_o     (hit_total_o),
    .miss_total_o    (miss_total_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule
`default_nettype wire

/* src/pofbc_ram.sv */
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module pofbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* src/pofbc_ctrl.sv */
// Controller: sequences accept, execute and pop phases of one transaction.
`default_nettype none
module pofbc_ctrl import pofbc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire pofbc_sts_t sts_i,
  output pofbc_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts_i.outcome)
          OC_SINGLE: begin
            // single result waits for room in the output register
            if (sts_i.out_free) begin
              cmd_o.commit      = 1'b1;
              cmd_o.load_single = 1'b1;
              state_d           = S_IDLE;
            end
          end
          OC_POP: begin
            cmd_o.commit    = 1'b1;
            cmd_o.start_pop = 1'b1;
            state_d         = S_POP;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_POP: begin
        if (sts_i.out_free) begin
          cmd_o.pop_load = 1'b1;
          if (sts_i.pop_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.pop_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

/* src/pofbc_dp.sv */
// Datapath: request registers, fill and offset memories, counters, output register.
`default_nettype none
module pofbc_dp import pofbc_pkg::*; #(
  parameter int unsigned NUM_CACHES = NUM_CACHES_DEF,
  parameter int unsigned NUM_ORDERS = NUM_ORDERS_DEF,
  parameter int unsigned MAX_LANE   = MAX_LANE_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [BUDGET_W-1:0] cfg_wdata_i,
  input  wire logic [OPCODE_W-1:0] opcode_i,
  input  wire logic [CINDEX_W-1:0] cache_index_i,
  input  wire logic [ORDER_W-1:0]  order_i,
  input  wire logic [OFFSET_W-1:0] block_offset_i,
  input  wire logic                out_stall_i,
  output logic                     out_valid_o,
  output logic      [STATUS_W-1:0] status_o,
  output logic      [OFFSET_W-1:0] result_offset_o,
  output logic      [ORDER_W-1:0]  result_order_o,
  output logic                     last_o,
  output logic      [BYTES_W-1:0]  cached_bytes_o,
  output logic      [COUNT_W-1:0]  hit_total_o,
  output logic      [COUNT_W-1:0]  miss_total_o,
  input  wire pofbc_cmd_t          cmd_i,
  output pofbc_sts_t               sts_o
);

  localparam int unsigned NSTK = NUM_CACHES * NUM_ORDERS;
  localparam int unsigned NENT = NSTK * MAX_LANE;
  localparam int unsigned CW   = (NUM_CACHES > 1) ? $clog2(NUM_CACHES) : 1;
  localparam int unsigned SW   = (NSTK > 1) ? $clog2(NSTK) : 1;
  localparam int unsigned AW   = (NENT > 1) ? $clog2(NENT) : 1;
  localparam int unsigned FW   = $clog2(MAX_LANE + 1);
  localparam int unsigned LW   = (MAX_LANE > 1) ? $clog2(MAX_LANE) : 1;

  // ---- input side: stack index of the incoming transaction
  logic [CINDEX_W-1:0] ci_wrap;
  logic [CW-1:0]       ci_mod;
  logic [ORDER_W-1:0]  ord_in;
  logic [SW-1:0]       stk_in;

  always_comb begin
    ci_wrap = cache_index_i;
    for (int i = 0; i < (1 << CINDEX_W); i++) begin
      if (32'(ci_wrap) >= NUM_CACHES) begin
        ci_wrap = ci_wrap - CINDEX_W'(NUM_CACHES);
      end
    end
    ci_mod = CW'(ci_wrap);
    ord_in = (32'(order_i) < NUM_ORDERS) ? order_i : '0;
    stk_in = SW'(ci_mod) * SW'(NUM_ORDERS) + SW'(ord_in);
  end

  // ---- request registers
  logic [OPCODE_W-1:0] op_q;
  logic [ORDER_W-1:0]  ord_q;
  logic [OFFSET_W-1:0] off_q;
  logic [SW-1:0]       stk_q;
  logic                fv_q;
  logic [NSTK-1:0]     fvalid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      ord_q <= order_i;
      off_q <= block_offset_i;
      stk_q <= stk_in;
      fv_q  <= fvalid_q[stk_in];
    end
  end

  // ---- budget register
  logic [BUDGET_W-1:0] budget_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= BUDGET_RESET;
    end else if (cfg_we_i) begin
      budget_q <= cfg_wdata_i;
    end
  end

  // ---- fill count memory, cleared through per-stack valid bits
  logic          fill_we;
  logic [FW-1:0] fill_wdata;
  logic [FW-1:0] fill_rdata;

  pofbc_ram #(
    .WIDTH (FW),
    .DEPTH (NSTK)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (stk_q),
    .wdata_i (fill_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (stk_in),
    .rdata_o (fill_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fvalid_q <= '0;
    end else if (fill_we) begin
      fvalid_q[stk_q] <= 1'b1;
    end
  end

  // ---- decode of the current request
  logic [FW-1:0]       fill_cur;
  logic                ord_ok;
  logic [SHIFT_W-1:0]  sh;
  logic [BUDGET_W-1:0] cap_raw;
  logic                cap_zero;
  logic                fill_zero;
  logic                free_ok;
  logic                is_miss;
  logic [FW-1:0]       n_pop;
  logic [BYTES_W-1:0]  blk_bytes;
  outcome_e            outcome;
  logic [STATUS_W-1:0] single_st;
  logic [STATUS_W-1:0] pop_st;

  always_comb begin
    fill_cur  = fv_q ? fill_rdata : '0;
    ord_ok    = (32'(ord_q) < NUM_ORDERS);
    sh        = SHIFT_W'(MIN_BLOCK_LOG2) + SHIFT_W'(ord_q);
    cap_raw   = budget_q >> sh;
    cap_zero  = !ord_ok || (cap_raw == '0);
    fill_zero = (fill_cur == '0);
    free_ok   = !cap_zero && (32'(fill_cur) < cap_raw) && (32'(fill_cur) < MAX_LANE);
    is_miss   = (op_q == OP_ALLOC) && !cap_zero && fill_zero;
    blk_bytes = BYTES_W'(1) << sh;
    if (op_q == OP_ALLOC) begin
      n_pop = FW'(1);
    end else if (32'(fill_cur) > MAX_RESULTS) begin
      n_pop = FW'(MAX_RESULTS);
    end else begin
      n_pop = fill_cur;
    end
    outcome   = OC_SINGLE;
    single_st = ST_UNCACHED;
    pop_st    = ST_DRAINED;
    case (op_q)
      OP_ALLOC: begin
        pop_st = ST_HIT;
        if (cap_zero) begin
          single_st = ST_UNCACHED;
        end else if (fill_zero) begin
          single_st = ST_EMPTY;
        end else begin
          outcome = OC_POP;
        end
      end
      OP_FREE: begin
        if (cap_zero) begin
          single_st = ST_UNCACHED;
        end else if (free_ok) begin
          single_st = ST_HIT;
        end else begin
          single_st = ST_FULL;
        end
      end
      OP_DRAIN: begin
        if (!ord_ok) begin
          single_st = ST_UNCACHED;
        end else if (fill_zero) begin
          single_st = ST_EMPTY;
        end else begin
          outcome = OC_POP;
        end
      end
      default: begin
        outcome = OC_IGNORE;
      end
    endcase
  end

  // ---- state updates on commit
  logic               store_we;
  logic [AW-1:0]      stk_base;
  logic [BYTES_W-1:0] byte_q, byte_d;
  logic [COUNT_W-1:0] hit_q, hit_d;
  logic [COUNT_W-1:0] miss_q, miss_d;

  always_comb begin
    store_we   = cmd_i.commit && (outcome == OC_SINGLE) && (op_q == OP_FREE) && free_ok;
    fill_we    = cmd_i.commit && ((outcome == OC_POP) || store_we);
    fill_wdata = (outcome == OC_POP) ? (fill_cur - n_pop) : (fill_cur + FW'(1));
    stk_base   = AW'(stk_q) * AW'(MAX_LANE);
    byte_d     = byte_q;
    hit_d      = hit_q;
    miss_d     = miss_q;
    if (cmd_i.commit) begin
      if (outcome == OC_POP) begin
        byte_d = byte_q - (BYTES_W'(n_pop) << sh);
        if (op_q == OP_ALLOC) begin
          hit_d = hit_q + COUNT_W'(1);
        end
      end else if (store_we) begin
        byte_d = byte_q + blk_bytes;
      end else if (is_miss) begin
        miss_d = miss_q + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
      hit_q  <= '0;
      miss_q <= '0;
    end else begin
      byte_q <= byte_d;
      hit_q  <= hit_d;
      miss_q <= miss_d;
    end
  end

  // ---- pop run: store reads walk down from the top of the stack
  logic [LW-1:0]       ptr_q;
  logic [FW-1:0]       rem_q;
  logic [STATUS_W-1:0] pop_st_q;
  logic [LW-1:0]       rd_slot;
  logic                store_re;
  logic [OFFSET_W-1:0] store_rdata;

  assign rd_slot  = cmd_i.start_pop ? LW'(32'(fill_cur) - 32'd1) : ptr_q;
  assign store_re = cmd_i.start_pop || cmd_i.pop_next;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_pop) begin
      ptr_q    <= LW'(32'(fill_cur) - 32'd2);
      rem_q    <= n_pop;
      pop_st_q <= pop_st;
    end else if (cmd_i.pop_next) begin
      ptr_q <= ptr_q - LW'(1);
      rem_q <= rem_q - FW'(1);
    end
  end

  pofbc_ram #(
    .WIDTH (OFFSET_W),
    .DEPTH (NENT)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (stk_base + AW'(fill_cur)),
    .wdata_i (off_q),
    .re_i    (store_re),
    .raddr_i (stk_base + AW'(rd_slot)),
    .rdata_o (store_rdata)
  );

  // ---- output register
  logic                out_valid_q;
  logic                out_free;
  logic [STATUS_W-1:0] out_st_q;
  logic [OFFSET_W-1:0] out_off_q;
  logic [ORDER_W-1:0]  out_ord_q;
  logic                out_last_q;
  logic [BYTES_W-1:0]  out_bytes_q;
  logic [COUNT_W-1:0]  out_hit_q;
  logic [COUNT_W-1:0]  out_miss_q;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_single || cmd_i.pop_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_single || cmd_i.pop_load) begin
      out_ord_q   <= ord_q;
      out_bytes_q <= byte_d;
      out_hit_q   <= hit_d;
      out_miss_q  <= miss_d;
      if (cmd_i.pop_load) begin
        out_st_q   <= pop_st_q;
        out_off_q  <= store_rdata;
        out_last_q <= (rem_q == FW'(1));
      end else begin
        out_st_q   <= single_st;
        out_off_q  <= '0;
        out_last_q <= 1'b1;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_st_q;
  assign result_offset_o = out_off_q;
  assign result_order_o  = out_ord_q;
  assign last_o          = out_last_q;
  assign cached_bytes_o  = out_bytes_q;
  assign hit_total_o     = out_hit_q;
  assign miss_total_o    = out_miss_q;

  assign sts_o.outcome  = outcome;
  assign sts_o.out_free = out_free;
  assign sts_o.pop_last = (rem_q == FW'(1));

endmodule
`default_nettype wire

/* src/pofbc_checker.sv */
// Port-level checker for the free block cache and its bind to the top level.
`default_nettype none
module pofbc_checker import pofbc_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_i,
  input wire logic                out_valid_i,
  input wire logic                out_stall_i,
  input wire logic [STATUS_W-1:0] status_i,
  input wire logic [OFFSET_W-1:0] result_offset_i,
  input wire logic                last_i
);

  // one transaction in flight: accept always closes the input on the next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_i) |=> in_stall_i)
    else $error("input accepted back to back");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |=> (out_valid_i && $stable(status_i)
      && $stable(result_offset_i) && $stable(last_i)))
    else $error("stalled result changed");

  // only drain runs produce results that are not last
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i != ST_DRAINED) |-> last_i)
    else $error("non-drain result without last");

  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i != ST_HIT && status_i != ST_DRAINED)
      |-> (result_offset_i == '0))
    else $error("offset on a result that pops nothing");

endmodule

bind per_order_free_block_cache pofbc_checker u_pofbc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_i      (in_stall_o),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_i        (status_o),
  .result_offset_i (result_offset_o),
  .last_i          (last_o)
);
`default_nettype wire

/* test/tb.sv */
// Testbench for the per-order free block cache: directed table plus random traffic.
`timescale 1ns / 100ps
module tb;
  import pofbc_pkg::*;

  localparam int NC = NUM_CACHES_DEF;
  localparam int NO = NUM_ORDERS_DEF;
  localparam int ML = MAX_LANE_DEF;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  localparam int HOLD_CYCLES    = 120;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] offset;
    logic [ORDER_W-1:0]  order;
    logic                last;
    logic [BYTES_W-1:0]  bytes;
    logic [COUNT_W-1:0]  hits;
    logic [COUNT_W-1:0]  misses;
  } cache_reply_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [CINDEX_W-1:0] ci;
    logic [ORDER_W-1:0]  ord;
    logic [OFFSET_W-1:0] off;
    logic                typed;
    logic [STATUS_W-1:0] st;
    logic [OFFSET_W-1:0] st_off;
  } dir_row_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [BUDGET_W-1:0] cfg_wdata   = '0;
  logic                in_valid    = 1'b0;
  logic [OPCODE_W-1:0] opcode      = '0;
  logic [CINDEX_W-1:0] cache_index = '0;
  logic [ORDER_W-1:0]  order       = '0;
  logic [OFFSET_W-1:0] block_offset = '0;
  logic                out_stall   = 1'b0;

  logic                in_stall_o;
  logic                out_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [OFFSET_W-1:0] result_offset_o;
  logic [ORDER_W-1:0]  result_order_o;
  logic                last_o;
  logic [BYTES_W-1:0]  cached_bytes_o;
  logic [COUNT_W-1:0]  hit_total_o;
  logic [COUNT_W-1:0]  miss_total_o;

  // shadow copy of the cache contents
  logic [OFFSET_W-1:0] shadow_offsets [NC*NO*ML];
  logic [4:0]          shadow_fill [NC*NO];
  logic [BYTES_W-1:0]  shadow_bytes  = '0;
  logic [COUNT_W-1:0]  shadow_hits   = '0;
  logic [COUNT_W-1:0]  shadow_misses = '0;
  logic [BUDGET_W-1:0] shadow_budget = BUDGET_RESET;

  cache_reply_t awaited_replies [$];
  dir_row_t     dir_rows [$];
  int           err_count   = 0;
  int           idle_cycles = 0;
  int           hold_left   = 0;
  bit           hold_req    = 1'b0;
  bit           idle_on     = 1'b1;

  per_order_free_block_cache u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode),
    .cache_index_i   (cache_index),
    .order_i         (order),
    .block_offset_i  (block_offset),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .status_o        (status_o),
    .result_offset_o (result_offset_o),
    .result_order_o  (result_order_o),
    .last_o          (last_o),
    .cached_bytes_o  (cached_bytes_o),
    .hit_total_o     (hit_total_o),
    .miss_total_o    (miss_total_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int stack_cap(input logic [ORDER_W-1:0] ord);
    logic [63:0] c;
    if (int'(ord) >= NO) return 0;
    c = {32'd0, shadow_budget} >> (MIN_BLOCK_LOG2 + ord);
    if (c > ML) return ML;
    return int'(c);
  endfunction

  function automatic cache_reply_t make_reply(input logic [STATUS_W-1:0] st,
                                              input logic [OFFSET_W-1:0] off,
                                              input logic [ORDER_W-1:0] ord,
                                              input logic last);
    cache_reply_t r;
    r        = '0;
    r.status = st;
    r.offset = off;
    r.order  = ord;
    r.last   = last;
    return r;
  endfunction

  // Updates the shadow cache for one accepted request and queues its replies.
  task automatic apply_cache_request(input logic [OPCODE_W-1:0] op,
                                     input logic [CINDEX_W-1:0] ci,
                                     input logic [ORDER_W-1:0] ord,
                                     input logic [OFFSET_W-1:0] off);
    cache_reply_t       batch [MAX_RESULTS];
    int                 n;
    int                 cap;
    int                 slot;
    logic [4:0]         fill;
    logic [BYTES_W-1:0] blk;
    n    = 0;
    cap  = stack_cap(ord);
    slot = (int'(ci) % NC) * NO + int'(ord);
    fill = shadow_fill[slot];
    blk  = BYTES_W'(1);
    blk  = blk << (MIN_BLOCK_LOG2 + ord);
    case (op)
      OP_ALLOC: begin
        if (cap == 0) begin
          batch[n] = make_reply(ST_UNCACHED, '0, ord, 1'b1);
          n++;
        end else if (fill > 0) begin
          fill = fill - 5'd1;
          shadow_fill[slot] = fill;
          batch[n] = make_reply(ST_HIT, shadow_offsets[slot*ML + fill], ord, 1'b1);
          n++;
          shadow_bytes = shadow_bytes - blk;
          shadow_hits  = shadow_hits + 1;
        end else begin
          batch[n] = make_reply(ST_EMPTY, '0, ord, 1'b1);
          n++;
          shadow_misses = shadow_misses + 1;
        end
      end
      OP_FREE: begin
        if (cap == 0) begin
          batch[n] = make_reply(ST_UNCACHED, '0, ord, 1'b1);
          n++;
        end else if (int'(fill) < cap) begin
          shadow_offsets[slot*ML + fill] = off;
          shadow_fill[slot] = fill + 5'd1;
          shadow_bytes = shadow_bytes + blk;
          batch[n] = make_reply(ST_HIT, '0, ord, 1'b1);
          n++;
        end else begin
          batch[n] = make_reply(ST_FULL, '0, ord, 1'b1);
          n++;
        end
      end
      OP_DRAIN: begin
        if (int'(ord) >= NO) begin
          batch[n] = make_reply(ST_UNCACHED, '0, ord, 1'b1);
          n++;
        end else if (fill == 0) begin
          batch[n] = make_reply(ST_EMPTY, '0, ord, 1'b1);
          n++;
        end else begin
          // drain ignores capacity, so a lowered budget still empties the stack
          while (fill > 0 && n < MAX_RESULTS) begin
            fill = fill - 5'd1;
            batch[n] = make_reply(ST_DRAINED, shadow_offsets[slot*ML + fill], ord,
                                  (fill == 0) || (n + 1 == MAX_RESULTS));
            shadow_bytes = shadow_bytes - blk;
            n++;
          end
          shadow_fill[slot] = fill;
        end
      end
      default: begin
      end
    endcase
    for (int k = 0; k < n; k++) begin
      batch[k].bytes  = shadow_bytes;
      batch[k].hits   = shadow_hits;
      batch[k].misses = shadow_misses;
      awaited_replies.push_back(batch[k]);
    end
  endtask

  // Call just after the clock rises; returns as soon as the cache accepts the transaction.
  task automatic send_request(input logic [OPCODE_W-1:0] op,
                              input logic [CINDEX_W-1:0] ci,
                              input logic [ORDER_W-1:0] ord,
                              input logic [OFFSET_W-1:0] off);
    while (idle_on && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    cache_index  <= ci;
    order        <= ord;
    block_offset <= off;
    @(posedge clk);
    while (in_stall_o !== 1'b0) @(posedge clk);
    apply_cache_request(op, ci, ord, off);
  endtask

  function automatic logic [OFFSET_W-1:0] rand_offset();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[OFFSET_W-1:0];
  endfunction

  task automatic send_random(input int count);
    logic [OPCODE_W-1:0] op;
    logic [CINDEX_W-1:0] ci;
    logic [ORDER_W-1:0]  ord;
    int                  pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 40)      op = OP_FREE;
      else if (pick < 75) op = OP_ALLOC;
      else if (pick < 92) op = OP_DRAIN;
      else                op = OP_UNUSED;
      // most traffic lands on a few stacks so they fill and empty often
      ci  = ($urandom_range(99) < 70) ? CINDEX_W'($urandom_range(1)) : CINDEX_W'($urandom_range(7));
      ord = ($urandom_range(99) < 70) ? ORDER_W'($urandom_range(2)) : ORDER_W'($urandom_range(15));
      send_request(op, ci, ord, rand_offset());
    end
  endtask

  // one past capacity, then a full drain
  task automatic fill_and_drain(input logic [CINDEX_W-1:0] ci, input logic [ORDER_W-1:0] ord);
    repeat (ML + 1) send_request(OP_FREE, ci, ord, rand_offset());
    send_request(OP_DRAIN, ci, ord, rand_offset());
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_budget(input logic [BUDGET_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    shadow_budget = value;
  endtask

  function automatic dir_row_t row(input logic [OPCODE_W-1:0] op,
                                   input logic [CINDEX_W-1:0] ci,
                                   input logic [ORDER_W-1:0] ord,
                                   input logic [OFFSET_W-1:0] off,
                                   input logic typed,
                                   input logic [STATUS_W-1:0] st,
                                   input logic [OFFSET_W-1:0] st_off);
    dir_row_t r;
    r.op = op; r.ci = ci; r.ord = ord; r.off = off;
    r.typed = typed; r.st = st; r.st_off = st_off;
    return r;
  endfunction

  function automatic int field_differs(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    cache_reply_t want;
    if (rst_n && out_valid_o === 1'b1 && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        $error("transaction with nothing awaited: status %0h offset %0h", status_o,
               result_offset_o);
        err_count++;
      end else begin
        want = awaited_replies.pop_front();
        err_count += field_differs("status", want.status, status_o);
        err_count += field_differs("result_offset", want.offset, result_offset_o);
        err_count += field_differs("result_order", want.order, result_order_o);
        err_count += field_differs("last", want.last, last_o);
        err_count += field_differs("cached_bytes", want.bytes, cached_bytes_o);
        err_count += field_differs("hit_total", want.hits, hit_total_o);
        err_count += field_differs("miss_total", want.misses, miss_total_o);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 35);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    dir_row_t r;
    cache_reply_t t;
    foreach (shadow_fill[i]) shadow_fill[i] = '0;

    // reset budget 1 MiB: orders 0..4 hold 16, order 7 holds 2, order 8 holds 1, 9 up uncached
    dir_rows.push_back(row(OP_ALLOC, 3'd0, 4'd0, '0, 1'b1, ST_EMPTY, '0));
    dir_rows.push_back(row(OP_DRAIN, 3'd0, 4'd0, '0, 1'b1, ST_EMPTY, '0));
    dir_rows.push_back(row(OP_ALLOC, 3'd7, 4'd15, '0, 1'b1, ST_UNCACHED, '0));
    dir_rows.push_back(row(OP_FREE, 3'd7, 4'd15, '1, 1'b1, ST_UNCACHED, '0));
    dir_rows.push_back(row(OP_DRAIN, 3'd7, 4'd15, '0, 1'b1, ST_EMPTY, '0));
    dir_rows.push_back(row(OP_FREE, 3'd0, 4'd0, '1, 1'b1, ST_HIT, '0));
    dir_rows.push_back(row(OP_FREE, 3'd0, 4'd0, '0, 1'b1, ST_HIT, '0));
    dir_rows.push_back(row(OP_ALLOC, 3'd0, 4'd0, '1, 1'b1, ST_HIT, '0));
    dir_rows.push_back(row(OP_ALLOC, 3'd0, 4'd0, '0, 1'b1, ST_HIT, '1));
    dir_rows.push_back(row(OP_FREE, 3'd7, 4'd8, 48'h5555_5555_5555, 1'b1, ST_HIT, '0));
    dir_rows.push_back(row(OP_FREE, 3'd7, 4'd8, 48'hAAAA_AAAA_AAAA, 1'b1, ST_FULL, '0));
    dir_rows.push_back(row(OP_ALLOC, 3'd7, 4'd9, '0, 1'b1, ST_UNCACHED, '0));
    dir_rows.push_back(row(OP_UNUSED, 3'd5, 4'd3, 48'h1234_5678_9ABC, 1'b0, '0, '0));
    dir_rows.push_back(row(OP_FREE, 3'd4, 4'd7, 48'h0123_4567_89AB, 1'b0, '0, '0));
    dir_rows.push_back(row(OP_FREE, 3'd4, 4'd7, 48'h8000_0000_0001, 1'b0, '0, '0));
    dir_rows.push_back(row(OP_FREE, 3'd4, 4'd7, 48'h7FFF_FFFF_FFFE, 1'b1, ST_FULL, '0));
    dir_rows.push_back(row(OP_DRAIN, 3'd4, 4'd7, '0, 1'b0, '0, '0));
    dir_rows.push_back(row(OP_ALLOC, 3'd4, 4'd7, '0, 1'b1, ST_EMPTY, '0));
    dir_rows.push_back(row(OP_FREE, 3'd3, 4'd4, 48'hC3C3_0F0F_A5A5, 1'b0, '0, '0));
    dir_rows.push_back(row(OP_DRAIN, 3'd3, 4'd4, '1, 1'b0, '0, '0));
    dir_rows.push_back(row(OP_ALLOC, 3'd0, 4'd0, '0, 1'b1, ST_EMPTY, '0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_request(r.op, r.ci, r.ord, r.off);
      if (r.typed) begin
        t        = awaited_replies[awaited_replies.size()-1];
        t.status = r.st;
        t.offset = r.st_off;
        t.last   = 1'b1;
        awaited_replies[awaited_replies.size()-1] = t;
      end
    end

    // long receiver hold-off while requests keep coming
    hold_req = 1'b1;
    send_random(25);
    fill_and_drain(3'd2, 4'd0);
    settle();

    // every order cached at full depth, no idling on either side
    write_budget('1);
    idle_on = 1'b0;
    fill_and_drain(3'd1, 4'd15);
    send_random(25);
    settle();
    idle_on = 1'b1;

    // budget dropped below the current fill of many stacks
    write_budget(32'h0000_2000);
    send_random(20);
    settle();

    write_budget('0);
    send_random(15);
    settle();

    write_budget($urandom >> $urandom_range(31));
    send_random(20);
    settle();

    if (awaited_replies.size() != 0) begin
      $error("%0d transactions never arrived", awaited_replies.size());
      err_count++;
    end
    if (err_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
